// File: hw/rtl/qpr_pkg.sv
package qpr_pkg;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 3;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_REAL = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_I    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_J    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_QUAT_K    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIVOT_Z   = 3'd4;

    // Reset values before truncation to the register widths.
    localparam logic [31:0] RESET_QUAT_REAL = 32'd16384;
    localparam logic [31:0] RESET_PIVOT_Z   = 32'd4096;

    // Control that travels down the pipeline next to the data.
    typedef struct packed {
        logic valid;
        logic last;
    } qpr_ctrl_t;

endpackage

// File: hw/rtl/quaternion_point_rotation.sv
// Channel        Signals                                         Direction
// -------------  ----------------------------------------------  ---------
// request        start, busy, point_x/y/z, last_point            in, busy out
// result         result_valid, rotated_x/y/z, last_rotated       out
// configuration  cfg_write, cfg_index, cfg_data                  in
//
// A request is taken on every clock edge with start high; busy stays low
// because the pipeline never holds, so one point per cycle is sustained.
// Each result passes through five register stages: products, matrix,
// matrix times point, row sums, rounding and saturation. The result is
// shown for one cycle under result_valid and the receiver cannot stall
// it. Reset clears the valid bits and loads the default quaternion
// (identity) and pivot.

module quaternion_point_rotation #(
    parameter int COORD_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    output logic                          result_valid,
    output logic signed [COORD_WIDTH-1:0] rotated_x,
    output logic signed [COORD_WIDTH-1:0] rotated_y,
    output logic signed [COORD_WIDTH-1:0] rotated_z,
    output logic                          last_rotated,
    input  logic                          cfg_write,
    input  logic [qpr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [(COORD_WIDTH > QUAT_WIDTH ? COORD_WIDTH : QUAT_WIDTH)-1:0] cfg_data
);

    localparam int MW = 2 * QUAT_WIDTH + 2;

    // Configuration registers, read directly by the stages. Change them
    // only with no request in the pipeline; the block does not check this.
    logic signed [QUAT_WIDTH-1:0]  quat_real_reg;
    logic signed [QUAT_WIDTH-1:0]  quat_i_reg;
    logic signed [QUAT_WIDTH-1:0]  quat_j_reg;
    logic signed [QUAT_WIDTH-1:0]  quat_k_reg;
    logic signed [COORD_WIDTH-1:0] pivot_z_reg;

    qpr_pkg::qpr_ctrl_t            in_ctrl;
    qpr_pkg::qpr_ctrl_t            mat_ctrl;
    qpr_pkg::qpr_ctrl_t            res_ctrl;
    logic signed [MW-1:0]          m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [COORD_WIDTH-1:0] mat_x, mat_y;
    logic signed [COORD_WIDTH:0]   mat_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_real_reg <= qpr_pkg::RESET_QUAT_REAL[QUAT_WIDTH-1:0];
            quat_i_reg    <= '0;
            quat_j_reg    <= '0;
            quat_k_reg    <= '0;
            pivot_z_reg   <= qpr_pkg::RESET_PIVOT_Z[COORD_WIDTH-1:0];
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                qpr_pkg::REG_QUAT_REAL: quat_real_reg <= cfg_data[QUAT_WIDTH-1:0];
                qpr_pkg::REG_QUAT_I:    quat_i_reg    <= cfg_data[QUAT_WIDTH-1:0];
                qpr_pkg::REG_QUAT_J:    quat_j_reg    <= cfg_data[QUAT_WIDTH-1:0];
                qpr_pkg::REG_QUAT_K:    quat_k_reg    <= cfg_data[QUAT_WIDTH-1:0];
                qpr_pkg::REG_PIVOT_Z:   pivot_z_reg   <= cfg_data[COORD_WIDTH-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // The pipeline never holds, so a request is taken whenever start is high.
    assign busy         = 1'b0;
    assign in_ctrl.valid = start;
    assign in_ctrl.last  = last_point;

    // Stages one and two: the rotation matrix, with the point shifted by the
    // pivot traveling next to it.
    qpr_matrix #(
        .COORD_WIDTH(COORD_WIDTH),
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctrl (in_ctrl),
        .quat_a  (quat_real_reg),
        .quat_b  (quat_i_reg),
        .quat_c  (quat_j_reg),
        .quat_d  (quat_k_reg),
        .pivot   (pivot_z_reg),
        .in_x    (point_x),
        .in_y    (point_y),
        .in_z    (point_z),
        .out_ctrl(mat_ctrl),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22),
        .out_x   (mat_x),
        .out_y   (mat_y),
        .out_z   (mat_z)
    );

    // Stages three to five: matrix times point, rounding back to the
    // coordinate format, pivot restored and saturation.
    qpr_transform #(
        .COORD_WIDTH(COORD_WIDTH),
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_transform (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctrl (mat_ctrl),
        .m00     (m00),
        .m01     (m01),
        .m02     (m02),
        .m10     (m10),
        .m11     (m11),
        .m12     (m12),
        .m20     (m20),
        .m21     (m21),
        .m22     (m22),
        .in_x    (mat_x),
        .in_y    (mat_y),
        .in_z    (mat_z),
        .pivot   (pivot_z_reg),
        .out_ctrl(res_ctrl),
        .out_x   (rotated_x),
        .out_y   (rotated_y),
        .out_z   (rotated_z)
    );

    assign result_valid = res_ctrl.valid;
    assign last_rotated = res_ctrl.last;

endmodule

// File: hw/rtl/qpr_matrix.sv
// Builds the rotation matrix from the quaternion over two stages while the
// point, already shifted by the pivot, travels alongside.
module qpr_matrix #(
    parameter int COORD_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  qpr_pkg::qpr_ctrl_t            in_ctrl,
    input  logic signed [QUAT_WIDTH-1:0]  quat_a,
    input  logic signed [QUAT_WIDTH-1:0]  quat_b,
    input  logic signed [QUAT_WIDTH-1:0]  quat_c,
    input  logic signed [QUAT_WIDTH-1:0]  quat_d,
    input  logic signed [COORD_WIDTH-1:0] pivot,
    input  logic signed [COORD_WIDTH-1:0] in_x,
    input  logic signed [COORD_WIDTH-1:0] in_y,
    input  logic signed [COORD_WIDTH-1:0] in_z,
    output qpr_pkg::qpr_ctrl_t            out_ctrl,
    output logic signed [2*QUAT_WIDTH+1:0] m00,
    output logic signed [2*QUAT_WIDTH+1:0] m01,
    output logic signed [2*QUAT_WIDTH+1:0] m02,
    output logic signed [2*QUAT_WIDTH+1:0] m10,
    output logic signed [2*QUAT_WIDTH+1:0] m11,
    output logic signed [2*QUAT_WIDTH+1:0] m12,
    output logic signed [2*QUAT_WIDTH+1:0] m20,
    output logic signed [2*QUAT_WIDTH+1:0] m21,
    output logic signed [2*QUAT_WIDTH+1:0] m22,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH:0]   out_z
);

    localparam int PRW = 2 * QUAT_WIDTH;
    localparam int MW  = 2 * QUAT_WIDTH + 2;
    localparam int ZW  = COORD_WIDTH + 1;

    // Stage one: the ten coefficient products and the shifted point.
    qpr_pkg::qpr_ctrl_t            ctrl1_reg;
    logic signed [PRW-1:0]         aa_reg, bb_reg, cc_reg, dd_reg;
    logic signed [PRW-1:0]         ab_reg, ac_reg, ad_reg;
    logic signed [PRW-1:0]         bc_reg, bd_reg, cd_reg;
    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg;
    logic signed [ZW-1:0]          z1_reg;
    logic signed [ZW-1:0]          z1_next;

    // Stage two: the matrix.
    qpr_pkg::qpr_ctrl_t            ctrl2_reg;
    logic signed [MW-1:0]          m00_reg, m01_reg, m02_reg;
    logic signed [MW-1:0]          m10_reg, m11_reg, m12_reg;
    logic signed [MW-1:0]          m20_reg, m21_reg, m22_reg;
    logic signed [MW-1:0]          m00_next, m01_next, m02_next;
    logic signed [MW-1:0]          m10_next, m11_next, m12_next;
    logic signed [MW-1:0]          m20_next, m21_next, m22_next;
    logic signed [COORD_WIDTH-1:0] x2_reg, y2_reg;
    logic signed [ZW-1:0]          z2_reg;

    // The shifted z keeps one extra bit and is never clamped.
    assign z1_next = ZW'(in_z) - ZW'(pivot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end
        else
        begin
            ctrl1_reg <= in_ctrl;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg <= PRW'(quat_a) * PRW'(quat_a);
        bb_reg <= PRW'(quat_b) * PRW'(quat_b);
        cc_reg <= PRW'(quat_c) * PRW'(quat_c);
        dd_reg <= PRW'(quat_d) * PRW'(quat_d);
        ab_reg <= PRW'(quat_a) * PRW'(quat_b);
        ac_reg <= PRW'(quat_a) * PRW'(quat_c);
        ad_reg <= PRW'(quat_a) * PRW'(quat_d);
        bc_reg <= PRW'(quat_b) * PRW'(quat_c);
        bd_reg <= PRW'(quat_b) * PRW'(quat_d);
        cd_reg <= PRW'(quat_c) * PRW'(quat_d);
        x1_reg <= in_x;
        y1_reg <= in_y;
        z1_reg <= z1_next;
    end

    always_comb
    begin
        m00_next = MW'(aa_reg) + MW'(bb_reg) - MW'(cc_reg) - MW'(dd_reg);
        m01_next = (MW'(bc_reg) - MW'(ad_reg)) <<< 1;
        m02_next = (MW'(bd_reg) + MW'(ac_reg)) <<< 1;
        m10_next = (MW'(bc_reg) + MW'(ad_reg)) <<< 1;
        m11_next = MW'(aa_reg) - MW'(bb_reg) + MW'(cc_reg) - MW'(dd_reg);
        m12_next = (MW'(cd_reg) - MW'(ab_reg)) <<< 1;
        m20_next = (MW'(bd_reg) - MW'(ac_reg)) <<< 1;
        m21_next = (MW'(cd_reg) + MW'(ab_reg)) <<< 1;
        m22_next = MW'(aa_reg) - MW'(bb_reg) - MW'(cc_reg) + MW'(dd_reg);
    end

    always_ff @(posedge clk)
    begin
        m00_reg <= m00_next;
        m01_reg <= m01_next;
        m02_reg <= m02_next;
        m10_reg <= m10_next;
        m11_reg <= m11_next;
        m12_reg <= m12_next;
        m20_reg <= m20_next;
        m21_reg <= m21_next;
        m22_reg <= m22_next;
        x2_reg  <= x1_reg;
        y2_reg  <= y1_reg;
        z2_reg  <= z1_reg;
    end

    assign out_ctrl = ctrl2_reg;
    assign m00      = m00_reg;
    assign m01      = m01_reg;
    assign m02      = m02_reg;
    assign m10      = m10_reg;
    assign m11      = m11_reg;
    assign m12      = m12_reg;
    assign m20      = m20_reg;
    assign m21      = m21_reg;
    assign m22      = m22_reg;
    assign out_x    = x2_reg;
    assign out_y    = y2_reg;
    assign out_z    = z2_reg;

endmodule

// File: hw/rtl/qpr_transform.sv
// Multiplies the matrix by the point, sums and rounds each row, adds the
// pivot back to z and saturates, over three stages.
module qpr_transform #(
    parameter int COORD_WIDTH = 16,
    parameter int QUAT_WIDTH  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  qpr_pkg::qpr_ctrl_t             in_ctrl,
    input  logic signed [2*QUAT_WIDTH+1:0] m00,
    input  logic signed [2*QUAT_WIDTH+1:0] m01,
    input  logic signed [2*QUAT_WIDTH+1:0] m02,
    input  logic signed [2*QUAT_WIDTH+1:0] m10,
    input  logic signed [2*QUAT_WIDTH+1:0] m11,
    input  logic signed [2*QUAT_WIDTH+1:0] m12,
    input  logic signed [2*QUAT_WIDTH+1:0] m20,
    input  logic signed [2*QUAT_WIDTH+1:0] m21,
    input  logic signed [2*QUAT_WIDTH+1:0] m22,
    input  logic signed [COORD_WIDTH-1:0]  in_x,
    input  logic signed [COORD_WIDTH-1:0]  in_y,
    input  logic signed [COORD_WIDTH:0]    in_z,
    input  logic signed [COORD_WIDTH-1:0]  pivot,
    output qpr_pkg::qpr_ctrl_t             out_ctrl,
    output logic signed [COORD_WIDTH-1:0]  out_x,
    output logic signed [COORD_WIDTH-1:0]  out_y,
    output logic signed [COORD_WIDTH-1:0]  out_z
);

    localparam int MW = 2 * QUAT_WIDTH + 2;
    localparam int PW = MW + COORD_WIDTH + 1;
    localparam int AW = PW + 3;
    localparam int PS = 2 * (QUAT_WIDTH - 2);

    localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (PS - 1);
    localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

    function automatic logic signed [COORD_WIDTH-1:0] saturate(
        input logic signed [AW-1:0] v
    );
        logic signed [COORD_WIDTH-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[COORD_WIDTH-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[COORD_WIDTH-1:0];
        end
        else
        begin
            r = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

    // Stage three: nine products.
    qpr_pkg::qpr_ctrl_t    ctrl3_reg;
    logic signed [PW-1:0]  p00_reg, p01_reg, p02_reg;
    logic signed [PW-1:0]  p10_reg, p11_reg, p12_reg;
    logic signed [PW-1:0]  p20_reg, p21_reg, p22_reg;
    logic signed [PW-1:0]  xe, ye, ze;

    // Stage four: row sums with the rounding offset.
    qpr_pkg::qpr_ctrl_t    ctrl4_reg;
    logic signed [AW-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [AW-1:0]  sx_next, sy_next, sz_next;

    // Stage five: rounded, pivot restored, saturated.
    qpr_pkg::qpr_ctrl_t            ctrl5_reg;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [AW-1:0]          rz_sum;

    assign xe = PW'(in_x);
    assign ye = PW'(in_y);
    assign ze = PW'(in_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else
        begin
            ctrl3_reg <= in_ctrl;
            ctrl4_reg <= ctrl3_reg;
            ctrl5_reg <= ctrl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p00_reg <= PW'(m00) * xe;
        p01_reg <= PW'(m01) * ye;
        p02_reg <= PW'(m02) * ze;
        p10_reg <= PW'(m10) * xe;
        p11_reg <= PW'(m11) * ye;
        p12_reg <= PW'(m12) * ze;
        p20_reg <= PW'(m20) * xe;
        p21_reg <= PW'(m21) * ye;
        p22_reg <= PW'(m22) * ze;
    end

    always_comb
    begin
        sx_next = AW'(p00_reg) + AW'(p01_reg) + AW'(p02_reg) + HALF;
        sy_next = AW'(p10_reg) + AW'(p11_reg) + AW'(p12_reg) + HALF;
        sz_next = AW'(p20_reg) + AW'(p21_reg) + AW'(p22_reg) + HALF;
    end

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        sz_reg <= sz_next;
    end

    // The arithmetic shift floors, which with the half offset rounds ties up.
    assign rz_sum = (sz_reg >>> PS) + AW'(pivot);

    always_ff @(posedge clk)
    begin
        rx_reg <= saturate(sx_reg >>> PS);
        ry_reg <= saturate(sy_reg >>> PS);
        rz_reg <= saturate(rz_sum);
    end

    assign out_ctrl = ctrl5_reg;
    assign out_x    = rx_reg;
    assign out_y    = ry_reg;
    assign out_z    = rz_reg;

endmodule

// File: hw/rtl/qpr_checker.sv
module qpr_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic last_point,
    input logic result_valid,
    input logic last_rotated
);

    localparam int LATENCY = 5;

    // The pipeline never pushes back on requests.
    assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // Every accepted request yields a result after the pipeline latency.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("request lost");

    // No result appears without a request that far back.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy && rst_n, LATENCY))
        else $error("result without request");

    // The batch flag follows its point through the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last_rotated == $past(last_point, LATENCY)))
        else $error("last flag mismatch");

endmodule

bind quaternion_point_rotation qpr_checker u_qpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .last_point  (last_point),
    .result_valid(result_valid),
    .last_rotated(last_rotated)
);

// File: tb/sv/tb_quaternion_point_rotation.sv
module tb_quaternion_point_rotation;

    // Widths of the block as built here, and of its configuration data port.
    localparam int COORD_W = 16;
    localparam int QUAT_W = 16;
    localparam int CFG_W = (COORD_W > QUAT_W) ? COORD_W : QUAT_W;
    localparam int IDX_W = qpr_pkg::CFG_INDEX_WIDTH;

    // The rotation matrix holds squared Q1.14 terms, so every row sum carries
    // twice the quaternion fraction bits before it is rounded back to Q4.11.
    localparam int PROD_SHIFT = 2 * (QUAT_W - 2);
    localparam longint ROUND_HALF = longint'(1) << (PROD_SHIFT - 1);
    localparam int COORD_MAX = int'((longint'(1) << (COORD_W - 1)) - 1);
    localparam int COORD_MIN = -COORD_MAX - 1;

    // The pipeline is five stages deep. Before a register write, and again at
    // the end, the bench lets this many empty cycles pass after the last result.
    localparam int DRAIN_CYCLES = 8;

    // The longest correct silence is the largest sender gap plus the
    // pipeline and the drain pause, so this limit is far above any valid run.
    localparam int WATCHDOG_LIMIT = 2000;

    localparam int RANDOM_PHASES = 12;
    localparam int POINTS_PER_PHASE = 62;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } coord_triple_t;

    typedef enum logic [1:0] {
        WORK_POINT,
        WORK_WRITE,
        WORK_DRAIN
    } work_kind_t;

    typedef struct {
        work_kind_t       kind;
        coord_triple_t    point;
        logic [IDX_W-1:0] index;
        logic [CFG_W-1:0] data;
    } work_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] point_x = '0;
    logic signed [COORD_W-1:0] point_y = '0;
    logic signed [COORD_W-1:0] point_z = '0;
    logic last_point = 1'b0;
    logic result_valid;
    logic signed [COORD_W-1:0] rotated_x;
    logic signed [COORD_W-1:0] rotated_y;
    logic signed [COORD_W-1:0] rotated_z;
    logic last_rotated;
    logic cfg_write = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // The bench keeps its own copy of the orientation and the pivot. These
    // start at the documented reset values and follow every register write
    // that the block sees, so each request is predicted against the setting
    // that the block itself uses at that clock edge.
    logic signed [QUAT_W-1:0] orient_real = QUAT_W'(qpr_pkg::RESET_QUAT_REAL);
    logic signed [QUAT_W-1:0] orient_i = '0;
    logic signed [QUAT_W-1:0] orient_j = '0;
    logic signed [QUAT_W-1:0] orient_k = '0;
    logic signed [COORD_W-1:0] pivot_height = COORD_W'(qpr_pkg::RESET_PIVOT_Z);

    work_item_t pending_work[$];
    coord_triple_t expected_points[$];

    // Handshake bookkeeping. The monitor writes request_taken and quiet_cycles at
    // the rising edge and the driver reads them at the falling edge, so the two
    // never touch them in the same time step; the rest belong to one side alone.
    logic request_taken = 1'b0;
    int quiet_cycles = 0;
    int stall_cycles = 0;
    int gap_left = 0;
    logic burst_mode = 1'b0;

    int error_count = 0;
    int points_checked = 0;
    int writes_done = 0;
    int settings_used = 1;
    int last_flags_seen = 0;

    quaternion_point_rotation #(
        .COORD_WIDTH(COORD_W),
        .QUAT_WIDTH (QUAT_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .last_point  (last_point),
        .result_valid(result_valid),
        .rotated_x   (rotated_x),
        .rotated_y   (rotated_y),
        .rotated_z   (rotated_z),
        .last_rotated(last_rotated),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp a rounded coordinate into the signed output range.
    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint value);
        if (value > COORD_MAX)
            return COORD_W'(COORD_MAX);
        if (value < COORD_MIN)
            return COORD_W'(COORD_MIN);
        return COORD_W'(value);
    endfunction

    // Rotated point for one request under the current orientation and pivot.
    // The sandwich product q*v*conj(q) is written out as its 3x3 matrix with
    // unnormalized terms, so a non-unit quaternion also scales by |q|^2. The
    // shifted z keeps one extra bit and is not clamped before the rotation.
    // Each row sum is rounded once with ties toward plus infinity; the
    // arithmetic right shift of a signed value is exactly a floor.
    function automatic coord_triple_t rotate_point(input coord_triple_t p);
        longint a, b, c, d, pz, x, y, z;
        longint aa, bb, cc, dd, ab, ac, ad, bc, bd, cd;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        longint sum_x, sum_y, sum_z;
        coord_triple_t r;
        a = orient_real;
        b = orient_i;
        c = orient_j;
        d = orient_k;
        pz = pivot_height;
        x = p.x;
        y = p.y;
        z = longint'(p.z) - pz;
        aa = a * a;
        bb = b * b;
        cc = c * c;
        dd = d * d;
        ab = a * b;
        ac = a * c;
        ad = a * d;
        bc = b * c;
        bd = b * d;
        cd = c * d;
        m00 = aa + bb - cc - dd;
        m01 = 2 * (bc - ad);
        m02 = 2 * (bd + ac);
        m10 = 2 * (bc + ad);
        m11 = aa - bb + cc - dd;
        m12 = 2 * (cd - ab);
        m20 = 2 * (bd - ac);
        m21 = 2 * (cd + ab);
        m22 = aa - bb - cc + dd;
        sum_x = (m00 * x + m01 * y + m02 * z + ROUND_HALF) >>> PROD_SHIFT;
        sum_y = (m10 * x + m11 * y + m12 * z + ROUND_HALF) >>> PROD_SHIFT;
        sum_z = ((m20 * x + m21 * y + m22 * z + ROUND_HALF) >>> PROD_SHIFT) + pz;
        r.x = clamp_coord(sum_x);
        r.y = clamp_coord(sum_y);
        r.z = clamp_coord(sum_z);
        r.last = p.last;
        return r;
    endfunction

    // Request driver. It changes the inputs only at the falling edge and
    // works through the pending queue: a point is raised on start and held
    // until the block takes it, a register write pulses cfg_write for one
    // cycle with start low, and a drain marker holds everything back until
    // the pipeline has emptied and stayed quiet for the drain pause. Between
    // points the driver waits the gap drawn for the next request; now and
    // then it switches into a burst mode with no gaps at all, so back-to-back
    // requests are covered as well as gaps on every pipeline phase.
    always @(negedge clk)
    begin : request_driver
        logic next_start;
        logic next_write;
        work_item_t item;
        if (rst_n)
        begin
            next_start = start;
            next_write = 1'b0;
            if (!start || request_taken)
            begin
                next_start = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_work.size() > 0)
                begin
                    item = pending_work[0];
                    case (item.kind)
                        WORK_POINT:
                        begin
                            point_x <= item.point.x;
                            point_y <= item.point.y;
                            point_z <= item.point.z;
                            last_point <= item.point.last;
                            next_start = 1'b1;
                            void'(pending_work.pop_front());
                            if ($urandom_range(0, 31) == 0)
                                burst_mode = !burst_mode;
                            gap_left = burst_mode ? 0 : $urandom_range(0, 15);
                        end
                        WORK_WRITE:
                        begin
                            cfg_index <= item.index;
                            cfg_data <= item.data;
                            next_write = 1'b1;
                            void'(pending_work.pop_front());
                        end
                        WORK_DRAIN:
                        begin
                            if (expected_points.size() == 0 && quiet_cycles >= DRAIN_CYCLES)
                                void'(pending_work.pop_front());
                        end
                        default:
                        begin
                            void'(pending_work.pop_front());
                        end
                    endcase
                end
            end
            start <= next_start;
            cfg_write <= next_write;
        end
    end

    // Result monitor. At each rising edge it samples what the block shows in
    // the cycle that this edge ends. A request taken at this edge is predicted
    // first, against the setting in force before any write at the same edge;
    // writes only happen with the pipeline empty, so the two never collide.
    // Every result is matched against the oldest prediction, field by field.
    always @(posedge clk)
    begin : result_monitor
        coord_triple_t sampled;
        coord_triple_t wanted;
        if (rst_n)
        begin
            request_taken = start && !busy;
            if (request_taken)
            begin
                sampled.x = point_x;
                sampled.y = point_y;
                sampled.z = point_z;
                sampled.last = last_point;
                expected_points.push_back(rotate_point(sampled));
            end

            if (result_valid)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result with no request outstanding: x=%0d y=%0d z=%0d last=%0b",
                           rotated_x, rotated_y, rotated_z, last_rotated);
                    error_count++;
                end
                else
                begin
                    wanted = expected_points.pop_front();
                    if (rotated_x !== wanted.x)
                    begin
                        $error("rotated_x: expected %0d, got %0d", wanted.x, rotated_x);
                        error_count++;
                    end
                    if (rotated_y !== wanted.y)
                    begin
                        $error("rotated_y: expected %0d, got %0d", wanted.y, rotated_y);
                        error_count++;
                    end
                    if (rotated_z !== wanted.z)
                    begin
                        $error("rotated_z: expected %0d, got %0d", wanted.z, rotated_z);
                        error_count++;
                    end
                    if (last_rotated !== wanted.last)
                    begin
                        $error("last_rotated: expected %0b, got %0b", wanted.last,
                               last_rotated);
                        error_count++;
                    end
                    points_checked++;
                    if (wanted.last)
                        last_flags_seen++;
                end
            end

            // Register writes land after the prediction above. An index past
            // the last register is ignored by the block and so here too.
            if (cfg_write)
            begin
                writes_done++;
                case (cfg_index)
                    qpr_pkg::REG_QUAT_REAL: orient_real = cfg_data[QUAT_W-1:0];
                    qpr_pkg::REG_QUAT_I:    orient_i = cfg_data[QUAT_W-1:0];
                    qpr_pkg::REG_QUAT_J:    orient_j = cfg_data[QUAT_W-1:0];
                    qpr_pkg::REG_QUAT_K:    orient_k = cfg_data[QUAT_W-1:0];
                    qpr_pkg::REG_PIVOT_Z:   pivot_height = cfg_data[COORD_W-1:0];
                    default:                ;
                endcase
            end

            if (expected_points.size() == 0 && !start && !result_valid)
                quiet_cycles++;
            else
                quiet_cycles = 0;

            // The watchdog only counts cycles in which no request, result or
            // register write is taken.
            if (request_taken || result_valid || cfg_write)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles, %0d results outstanding",
                         WATCHDOG_LIMIT, expected_points.size());
                $display("tb_quaternion_point_rotation: FAIL");
                $finish;
            end
        end
    end

    task automatic add_point(input int x, input int y, input int z, input bit last);
        work_item_t item;
        item.kind = WORK_POINT;
        item.point.x = COORD_W'(x);
        item.point.y = COORD_W'(y);
        item.point.z = COORD_W'(z);
        item.point.last = last;
        item.index = '0;
        item.data = '0;
        pending_work.push_back(item);
    endtask

    task automatic add_write(input logic [IDX_W-1:0] index, input int value);
        work_item_t item;
        item.kind = WORK_WRITE;
        item.point.x = '0;
        item.point.y = '0;
        item.point.z = '0;
        item.point.last = 1'b0;
        item.index = index;
        item.data = CFG_W'(value);
        pending_work.push_back(item);
    endtask

    // A new orientation and pivot. The pipeline is drained first, then all
    // five registers are written in a shuffled order, sometimes with a stray
    // write to an unused index mixed in.
    task automatic apply_setting(input int q_real, input int q_i, input int q_j, input int q_k,
                                 input int pivot);
        work_item_t item;
        int order[5];
        int swap_at;
        int held;
        item.kind = WORK_DRAIN;
        item.point.x = '0;
        item.point.y = '0;
        item.point.z = '0;
        item.point.last = 1'b0;
        item.index = '0;
        item.data = '0;
        pending_work.push_back(item);
        order = '{qpr_pkg::REG_QUAT_REAL, qpr_pkg::REG_QUAT_I, qpr_pkg::REG_QUAT_J,
                  qpr_pkg::REG_QUAT_K, qpr_pkg::REG_PIVOT_Z};
        for (int n = 4; n > 0; n--)
        begin
            swap_at = $urandom_range(0, n);
            held = order[n];
            order[n] = order[swap_at];
            order[swap_at] = held;
        end
        for (int n = 0; n < 5; n++)
        begin
            case (order[n])
                qpr_pkg::REG_QUAT_REAL: add_write(qpr_pkg::REG_QUAT_REAL, q_real);
                qpr_pkg::REG_QUAT_I:    add_write(qpr_pkg::REG_QUAT_I, q_i);
                qpr_pkg::REG_QUAT_J:    add_write(qpr_pkg::REG_QUAT_J, q_j);
                qpr_pkg::REG_QUAT_K:    add_write(qpr_pkg::REG_QUAT_K, q_k);
                default:                add_write(qpr_pkg::REG_PIVOT_Z, pivot);
            endcase
            if ($urandom_range(0, 3) == 0)
                add_write(IDX_W'($urandom_range(qpr_pkg::REG_PIVOT_Z + 1, (1 << IDX_W) - 1)),
                          int'($urandom));
        end
        settings_used++;
    endtask

    function automatic int pick_extreme();
        case ($urandom_range(0, 3))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 0;
            default: return $signed(COORD_W'($urandom));
        endcase
    endfunction

    function automatic int pick_component();
        case ($urandom_range(0, 2))
            0: return 16384;
            1: return -16384;
            default: return 0;
        endcase
    endfunction

    initial
    begin : stimulus
        real angle;
        real ax, ay, az, norm, half_sin;
        int q_real, q_i, q_j, q_k, pivot;
        int px, py, pz;

        // Directed points under the reset setting: identity orientation with
        // the pivot at 2.0, so every point must come back unchanged.
        add_point(0, 0, 0, 1'b0);
        add_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        add_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
        add_point(COORD_MAX, COORD_MIN, 4096, 1'b1);
        add_point(-1, 1, COORD_MIN, 1'b0);
        add_point(12345, -23456, COORD_MAX, 1'b1);

        // A real part of 0.5 scales by a quarter, which puts exact halves in
        // front of the rounding: ties must go toward plus infinity on both
        // sides of zero.
        apply_setting(8192, 0, 0, 0, 0);
        add_point(2, -2, 6, 1'b0);
        add_point(-6, 10, -10, 1'b1);
        add_point(COORD_MAX, COORD_MIN, 1, 1'b0);

        // A quarter turn about x with the default pivot. A z far below the
        // pivot shifts past the coordinate range and must survive unclamped
        // into y before the final clamp.
        apply_setting(11585, 11585, 0, 0, 4096);
        add_point(0, 0, COORD_MIN, 1'b0);
        add_point(0, COORD_MAX, COORD_MAX, 1'b1);
        add_point(COORD_MIN, COORD_MIN, 4096, 1'b0);

        // The most negative quaternion pattern, -2.0: the point is scaled by
        // four and most coordinates clamp at either end.
        apply_setting(-32768, 0, 0, 0, 0);
        add_point(COORD_MAX, COORD_MIN, 100, 1'b1);
        add_point(8191, -8192, -8193, 1'b0);

        // The register extremes: every component at +1.0 with the pivot at
        // the top, then every component at -1.0 with the pivot at the bottom.
        apply_setting(16384, 16384, 16384, 16384, COORD_MAX);
        add_point(100, -200, COORD_MIN, 1'b0);
        add_point(COORD_MAX, 0, COORD_MAX, 1'b1);
        apply_setting(-16384, -16384, -16384, -16384, COORD_MIN);
        add_point(-300, 400, COORD_MAX, 1'b0);
        add_point(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1);

        // Random phases. Half of the orientations are near-unit rotations, the kind
        // a vertex stream would see; the rest are scaled, extreme, zero or raw
        // bit patterns. Points are mostly full range, with a share of small
        // values, extremes and points close to the pivot.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 7))
                0:
                begin
                    q_real = $urandom_range(0, 32768) - 16384;
                    q_i = $urandom_range(0, 32768) - 16384;
                    q_j = $urandom_range(0, 32768) - 16384;
                    q_k = $urandom_range(0, 32768) - 16384;
                end
                1:
                begin
                    q_real = $signed(QUAT_W'($urandom));
                    q_i = $signed(QUAT_W'($urandom));
                    q_j = $signed(QUAT_W'($urandom));
                    q_k = $signed(QUAT_W'($urandom));
                end
                2:
                begin
                    q_real = pick_component();
                    q_i = pick_component();
                    q_j = pick_component();
                    q_k = pick_component();
                end
                3:
                begin
                    q_real = 0;
                    q_i = 0;
                    q_j = 0;
                    q_k = 0;
                end
                default:
                begin
                    angle = $urandom_range(0, 62831) / 10000.0;
                    ax = $urandom_range(0, 2000) - 1000.0;
                    ay = $urandom_range(0, 2000) - 1000.0;
                    az = $urandom_range(0, 2000) - 1000.0;
                    norm = $sqrt(ax * ax + ay * ay + az * az);
                    if (norm < 1.0)
                    begin
                        ax = 1.0;
                        norm = 1.0;
                    end
                    half_sin = $sin(angle / 2.0) * 16384.0 / norm;
                    q_real = $rtoi($cos(angle / 2.0) * 16384.0);
                    q_i = $rtoi(ax * half_sin);
                    q_j = $rtoi(ay * half_sin);
                    q_k = $rtoi(az * half_sin);
                end
            endcase
            case ($urandom_range(0, 4))
                0: pivot = COORD_MAX;
                1: pivot = COORD_MIN;
                2: pivot = 0;
                default: pivot = $signed(COORD_W'($urandom));
            endcase
            apply_setting(q_real, q_i, q_j, q_k, pivot);

            for (int n = 0; n < POINTS_PER_PHASE; n++)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        px = pick_extreme();
                        py = pick_extreme();
                        pz = pick_extreme();
                    end
                    1, 2:
                    begin
                        px = $urandom_range(0, 4096) - 2048;
                        py = $urandom_range(0, 4096) - 2048;
                        pz = $urandom_range(0, 4096) - 2048;
                    end
                    3:
                    begin
                        px = $urandom_range(0, 512) - 256;
                        py = $urandom_range(0, 512) - 256;
                        pz = pivot + $urandom_range(0, 512) - 256;
                    end
                    default:
                    begin
                        px = $signed(COORD_W'($urandom));
                        py = $signed(COORD_W'($urandom));
                        pz = $signed(COORD_W'($urandom));
                    end
                endcase
                add_point(px, py, pz, $urandom_range(0, 7) == 0);
            end
        end

        // Reset is asserted once and released at a falling edge so that the first
        // request follows cleanly.
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // The queue and start only move at falling edges, so they are checked
        // at rising edges; the prediction store and quiet counter only move at
        // rising edges, so the store is checked at falling edges.
        @(posedge clk);
        while (pending_work.size() != 0 || start)
            @(posedge clk);
        @(negedge clk);
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Checked %0d rotated points (%0d batch ends) under %0d orientation settings,",
                 points_checked, last_flags_seen, settings_used);
        $display("with %0d register writes and %0d mismatches.", writes_done, error_count);
        if (error_count == 0)
            $display("tb_quaternion_point_rotation: PASS");
        else
            $display("tb_quaternion_point_rotation: FAIL");
        $finish;
    end

endmodule

// File: quaternion_point_rotation.f
hw/rtl/qpr_pkg.sv
hw/rtl/qpr_matrix.sv
hw/rtl/qpr_transform.sv
hw/rtl/quaternion_point_rotation.sv
hw/rtl/qpr_checker.sv
tb/sv/tb_quaternion_point_rotation.sv
